// ===== sv/gsps_pkg.sv =====
// Package: sizes, reset values, request codes, table entry type and sequencer states of the group state poll scheduler.
package gsps_pkg;

  localparam int ENTRIES = 128;
  localparam int QDEPTH  = 128;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [31:0] EXPIRY_RESET  = 32'd3900000;

  // Request codes
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_TEL   = 3'd1;
  localparam logic [2:0] REQ_SET   = 3'd2;
  localparam logic [2:0] REQ_FLUSH = 3'd3;
  localparam logic [2:0] REQ_QUERY = 3'd4;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_EXPIRY  = 1'b1;

  typedef struct packed {
    logic [15:0] watch;
    logic        state;
    logic [31:0] stamp;
  } tbl_entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TICK,
    S_POP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_NEXT,
    S_PUSH,
    S_PUSH_RD,
    S_PUSH_CHK,
    S_TEL_RD,
    S_TEL_CHK,
    S_TEL_END,
    S_SET_RD,
    S_SET_WR,
    S_QRY_RD,
    S_QRY_CHK,
    S_DONE
  } state_t;

endpackage

// ===== sv/group_state_poll_scheduler_top.sv =====
// Top level: watched group table, read queue and the sequencer that serves each request.
//
// One request item is taken at a time and in_stall stays high until it is served. A tick that
// pops the queue issues the read of its oldest address; a tick that finds the queue empty scans
// the table one entry at a time, and each expired entry adds a duplicate search over the queue
// before its address is queued. A tick whose pending read timed out searches the queue the same
// way and queues that address again. A group telegram walks every table entry, any other telegram
// goes straight to the result, a set writes the entry and then queues its address, a query reads
// one entry, and a flush empties the queue and the pending read. The table memory is single-port.
// Table entries carry valid bits cleared by reset, so there is no clearing pass. The result
// sits in an output register, so the next item may be taken while it waits.
module group_state_poll_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [6:0]  entry_index,
  input  logic [15:0] group_address,
  input  logic        is_group_target,
  input  logic        is_write_or_answer,
  input  logic        one_bit_payload,
  input  logic        bit_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        read_valid,
  output logic [15:0] read_address,
  output logic        interested,
  output logic        entry_state,
  output logic        push_dropped,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import gsps_pkg::*;

  state_t state, state_next, ret;

  // latched request
  logic [2:0]    req;
  logic [6:0]    idx;
  logic [15:0]   ga;
  logic          grp, wr, onebit, val;

  // configuration
  logic [15:0]   rd_tmo;
  logic [31:0]   expiry;

  // scheduler state
  logic [QW-1:0] head, tail, kpos;
  logic [CW-1:0] count, kcnt;
  logic [15:0]   pend_addr;
  logic [31:0]   pend_since;
  logic [31:0]   now;

  // work registers
  logic [EW-1:0] ent;
  logic [15:0]   push_addr;
  logic          hit, dropped, rvalid, estate;
  logic [15:0]   raddr;

  // memories
  tbl_entry_t    tbl [ENTRIES];
  logic [ENTRIES-1:0] tbl_vld;
  logic [15:0]   ring [QDEPTH];
  tbl_entry_t    tbl_rd;
  logic          tbl_vld_rd;
  logic [15:0]   ring_rd;

  logic [EW-1:0] tbl_raddr;
  logic [QW-1:0] ring_raddr;
  logic          tbl_we, ring_we;
  tbl_entry_t    tbl_wdata;
  tbl_entry_t    e;
  logic          idx_ok, expired, timed_out, out_load;
  logic [QW-1:0] tail_inc, kpos_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // entry as seen: unwritten entries read as zero
  assign e = tbl_vld_rd ? tbl_rd : '0;
  assign idx_ok    = (32'(entry_index) < ENTRIES);
  assign expired   = ((now - e.stamp) > expiry);
  assign timed_out = ((now - pend_since) > {16'b0, rd_tmo});
  assign tail_inc  = (tail == QW'(QDEPTH - 1)) ? '0 : tail + 1'b1;
  assign kpos_inc  = (kpos == QW'(QDEPTH - 1)) ? '0 : kpos + 1'b1;
  assign out_load  = (state == S_DONE) && !(out_valid && out_stall);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory addresses and write strobes
  always_comb begin
    state_next = state;
    tbl_raddr  = ent;
    ring_raddr = kpos;
    tbl_we     = 1'b0;
    ring_we    = 1'b0;
    tbl_wdata  = '{watch: ga, state: val, stamp: now};
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (req_type)
            REQ_TICK:  state_next = S_TICK;
            REQ_TEL:   state_next = is_group_target ? S_TEL_RD : S_DONE;
            REQ_SET:   state_next = idx_ok ? S_SET_RD : S_DONE;
            REQ_QUERY: state_next = idx_ok ? S_QRY_RD : S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_TICK: begin
        ring_raddr = tail;
        if (pend_addr == 16'd0) begin
          state_next = (count != '0) ? S_POP : S_SCAN_RD;
        end else if (timed_out) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_POP:       state_next = S_DONE;
      S_SCAN_RD:   state_next = S_SCAN_CHK;
      S_SCAN_CHK:  state_next = expired ? S_PUSH : S_SCAN_NEXT;
      S_SCAN_NEXT: state_next = (ent == EW'(ENTRIES - 1)) ? S_DONE : S_SCAN_RD;
      S_PUSH:      state_next = (push_addr == 16'd0) ? ret : S_PUSH_RD;
      S_PUSH_RD: begin
        if (kcnt == count) begin
          ring_we    = (32'(count) < QDEPTH);
          state_next = ret;
        end else begin
          state_next = S_PUSH_CHK;
        end
      end
      S_PUSH_CHK:  state_next = (ring_rd == push_addr) ? ret : S_PUSH_RD;
      S_TEL_RD:    state_next = S_TEL_CHK;
      S_TEL_CHK: begin
        tbl_wdata = '{watch: e.watch, state: val, stamp: now};
        tbl_we    = (e.watch == ga) && wr && onebit;
        state_next = (ent == EW'(ENTRIES - 1)) ? S_TEL_END : S_TEL_RD;
      end
      S_TEL_END:   state_next = S_DONE;
      S_SET_RD: begin
        tbl_raddr  = EW'(idx);
        state_next = S_SET_WR;
      end
      S_SET_WR: begin
        tbl_raddr  = EW'(idx);
        tbl_wdata  = '{watch: ga, state: e.state, stamp: e.stamp};
        tbl_we     = 1'b1;
        state_next = S_PUSH;
      end
      S_QRY_RD: begin
        tbl_raddr  = EW'(idx);
        state_next = S_QRY_CHK;
      end
      S_QRY_CHK:   state_next = S_DONE;
      S_DONE:      state_next = out_load ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  // table memory with registered read
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tbl_raddr] <= tbl_wdata;
    end
    tbl_rd <= tbl[tbl_raddr];
  end

  // table valid bits and their registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_vld    <= '0;
      tbl_vld_rd <= 1'b0;
    end else begin
      if (tbl_we) begin
        tbl_vld[tbl_raddr] <= 1'b1;
      end
      tbl_vld_rd <= tbl_vld[tbl_raddr];
    end
  end

  // read queue memory with registered read
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[head] <= push_addr;
    end
    ring_rd <= ring[ring_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tmo <= TIMEOUT_RESET;
      expiry <= EXPIRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMEOUT: rd_tmo <= cfg_data[15:0];
        CFG_EXPIRY:  expiry <= cfg_data;
        default:     ;
      endcase
    end
  end

  // scheduler state and work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      pend_addr  <= '0;
      pend_since <= '0;
      now        <= '0;
      ret        <= S_DONE;
      ent        <= '0;
      kpos       <= '0;
      kcnt       <= '0;
      push_addr  <= '0;
      hit        <= 1'b0;
      dropped    <= 1'b0;
      rvalid     <= 1'b0;
      raddr      <= '0;
      estate     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            hit     <= 1'b0;
            dropped <= 1'b0;
            rvalid  <= 1'b0;
            raddr   <= '0;
            estate  <= 1'b0;
            ent     <= '0;
            ret     <= S_DONE;
            if (req_type == REQ_TICK) begin
              now <= now + 32'd1;
            end
            if (req_type == REQ_FLUSH) begin
              head       <= '0;
              tail       <= '0;
              count      <= '0;
              pend_addr  <= '0;
              pend_since <= '0;
            end
          end
        end
        S_TICK: begin
          if (pend_addr != 16'd0 && timed_out) begin
            push_addr  <= pend_addr;
            pend_addr  <= '0;
            pend_since <= '0;
          end
        end
        S_POP: begin
          rvalid     <= 1'b1;
          raddr      <= ring_rd;
          pend_addr  <= ring_rd;
          pend_since <= now;
          tail       <= tail_inc;
          count      <= count - 1'b1;
        end
        S_SCAN_CHK: begin
          if (expired) begin
            push_addr <= e.watch;
            ret       <= S_SCAN_NEXT;
          end
        end
        S_SCAN_NEXT: ent <= ent + 1'b1;
        S_PUSH: begin
          kpos <= tail;
          kcnt <= '0;
        end
        S_PUSH_RD: begin
          if (kcnt == count) begin
            if (ring_we) begin
              head  <= (head == QW'(QDEPTH - 1)) ? '0 : head + 1'b1;
              count <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_PUSH_CHK: begin
          kpos <= kpos_inc;
          kcnt <= kcnt + 1'b1;
        end
        S_TEL_CHK: begin
          if (e.watch == ga) begin
            hit <= 1'b1;
          end
          ent <= ent + 1'b1;
        end
        S_TEL_END: begin
          if (hit && wr && onebit && pend_addr == ga) begin
            pend_addr  <= '0;
            pend_since <= '0;
          end
        end
        S_SET_WR: push_addr <= ga;
        S_QRY_CHK: estate <= e.state;
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req    <= req_type;
      idx    <= entry_index;
      ga     <= group_address;
      grp    <= is_group_target;
      wr     <= is_write_or_answer;
      onebit <= one_bit_payload;
      val    <= bit_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_valid   <= rvalid;
      read_address <= raddr;
      interested   <= hit && (req == REQ_TEL) && grp;
      entry_state  <= estate;
      push_dropped <= dropped;
    end
  end

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= QDEPTH) else $error("queue count above depth");

  a_no_full_write: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> 32'(count) < QDEPTH) else $error("write into full queue");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("result not from done state");

  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    pend_addr == 16'd0 |-> pend_since == 32'd0) else $error("stale pending time");

  a_read_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> read_address != 16'd0) else $error("read of address zero");

endmodule
